// ===== src/chrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Consistent-hash ring table package
// Shared field widths, mode and status codes, and the beat and control types
// used by the ring cells and the top level.
// ----------------------------------------------------------------------------
package chrt_pkg;

	// Field widths fixed by the command and result formats.
	localparam int unsigned KEY_W   = 34;
	localparam int unsigned OWN_W   = 4;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned OCNT_W  = 9;

	// Default ring depth.
	localparam int unsigned RING_ENTRIES_DEF = 256;

	// Command modes.
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUP    = 3'd1;
	localparam logic [STAT_W-1:0] ST_ABSENT = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

	// Command beat.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key_hash;
		logic [OWN_W-1:0]  node_id;
	} req_t;

	// Result beat.
	typedef struct packed {
		logic [OWN_W-1:0]  owner_id;
		logic [STAT_W-1:0] status;
		logic [OCNT_W-1:0] entry_count;
	} rsp_t;

	// One ring entry as held in a cell and handed to a neighbor.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [OWN_W-1:0] owner;
	} entry_t;

	// Update command broadcast to every cell.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [KEY_W-1:0] key;
		logic [OWN_W-1:0] owner;
	} upd_t;

endpackage

// ===== src/chrt_cell.sv =====
// ----------------------------------------------------------------------------
// Ring cell
// Holds one sorted ring entry, compares it against the incoming key, and on
// an update either keeps its entry, takes the new one, or takes a neighbor's.
// ----------------------------------------------------------------------------
module chrt_cell import chrt_pkg::*; #(
	parameter int unsigned RING_ENTRIES = RING_ENTRIES_DEF,
	parameter int unsigned IDX          = 0,
	parameter int unsigned CNT_W        = $clog2(RING_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [KEY_W-1:0] load_key,
	input  logic [CNT_W-1:0] count,
	input  upd_t             upd,
	input  entry_t           left,
	input  logic             left_lt,
	input  entry_t           right,
	output entry_t           entry,
	output logic             lt,
	output logic             bnd,
	output logic             eq
);

	localparam logic             IS_FIRST = (IDX == 0);
	localparam logic             IS_LAST  = (IDX == RING_ENTRIES - 1);
	localparam logic [CNT_W-1:0] IDX_C    = CNT_W'(IDX);

	entry_t entry_q;
	logic   lt_q;
	logic   ge_q;
	logic   eq_q;
	logic   occupied;

	// The cell holds a live entry when its place lies below the entry count.
	assign occupied = (IDX_C < count);

	// Compare flags, captured when a command beat is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			ge_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (load) begin
			lt_q <= occupied && (entry_q.key < load_key);
			ge_q <= occupied && !(entry_q.key < load_key);
			eq_q <= occupied && (entry_q.key == load_key);
		end
	end

	// Entry storage: cells below the insert or remove point keep their entry,
	// the rest shift one place along the chain, the first taking an inserted entry.
	always_ff @(posedge clk) begin
		if (upd.ins && !lt_q) begin
			if (IS_FIRST || left_lt) begin
				entry_q.key   <= upd.key;
				entry_q.owner <= upd.owner;
			end else begin
				entry_q <= left;
			end
		end else if (upd.rem && !lt_q && !IS_LAST) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	// First live entry at or above the key.
	assign bnd   = ge_q && (IS_FIRST || left_lt);
	assign eq    = eq_q;

endmodule

// ===== src/consistent_hash_ring_table_core.sv =====
// ----------------------------------------------------------------------------
// Consistent-hash ring table core
// Sorted chain of ring cells with insert, remove and successor lookup.
// ----------------------------------------------------------------------------
// The result strobe done is registered from busy, which is set at the edge
// that accepts a command beat. No new command is accepted while busy is high;
// the cell compare at acceptance and the chain shift in the busy cycle set this.
// busy is high for the one cycle between acceptance and the update.
// Reset clears the entry count and control state; cell contents are not
// cleared. Results cannot be stalled and are shown for one cycle each.
// ----------------------------------------------------------------------------
module consistent_hash_ring_table_core import chrt_pkg::*; #(
	parameter int unsigned RING_ENTRIES = RING_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(RING_ENTRIES + 1);

	logic                   busy_q;
	logic                   done_q;
	rsp_t                   rsp_q;
	req_t                   cmd_q;
	logic [CNT_W-1:0]       count_q;
	logic                   load;

	entry_t                 entry_a [RING_ENTRIES];
	logic [RING_ENTRIES-1:0] lt_vec;
	logic [RING_ENTRIES-1:0] bnd_vec;
	logic [RING_ENTRIES-1:0] eq_vec;

	upd_t                   upd;
	logic                   hit;
	logic                   found;
	logic                   full;
	logic [OWN_W-1:0]       sel_owner;
	logic [CNT_W-1:0]       count_d;
	logic [OWN_W-1:0]       owner_d;
	logic [STAT_W-1:0]      status_d;
	logic [CNT_W+OCNT_W-1:0] count_ext;

	assign load = start && !busy_q;

	// Cell chain.
	for (genvar i = 0; i < RING_ENTRIES; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_lt;

		if (i == 0) begin : g_first
			assign left_e  = '0;
			assign left_lt = 1'b0;
		end else begin : g_mid
			assign left_e  = entry_a[i-1];
			assign left_lt = lt_vec[i-1];
		end
		if (i == RING_ENTRIES - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_nlast
			assign right_e = entry_a[i+1];
		end

		chrt_cell #(
			.RING_ENTRIES (RING_ENTRIES),
			.IDX          (i),
			.CNT_W        (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (load),
			.load_key (req.key_hash),
			.count    (count_q),
			.upd      (upd),
			.left     (left_e),
			.left_lt  (left_lt),
			.right    (right_e),
			.entry    (entry_a[i]),
			.lt       (lt_vec[i]),
			.bnd      (bnd_vec[i]),
			.eq       (eq_vec[i])
		);
	end

	// Successor owner: at most one boundary cell is set, so an AND-OR select works.
	always_comb begin
		sel_owner = '0;
		for (int i = 0; i < RING_ENTRIES; i++) begin
			sel_owner = sel_owner | (entry_a[i].owner & {OWN_W{bnd_vec[i]}});
		end
	end

	// Decision for the command in flight.
	always_comb begin
		hit      = |eq_vec;
		found    = |bnd_vec;
		full     = (count_q == CNT_W'(RING_ENTRIES));
		owner_d  = '0;
		status_d = ST_OK;
		count_d  = count_q;
		upd.ins  = 1'b0;
		upd.rem  = 1'b0;
		upd.key  = cmd_q.key_hash;
		upd.owner = cmd_q.node_id;
		unique case (cmd_q.mode)
			MODE_INSERT: begin
				if (hit) begin
					status_d = ST_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					upd.ins = busy_q;
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (!hit) begin
					status_d = ST_ABSENT;
				end else begin
					upd.rem = busy_q;
					count_d = count_q - CNT_W'(1);
				end
			end
			MODE_LOOKUP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (found) begin
					owner_d = sel_owner;
				end else begin
					owner_d = entry_a[0].owner;
				end
			end
			default: begin
			end
		endcase
	end

	// The reported count is the new entry count cut to its low OCNT_W bits.
	assign count_ext = {{OCNT_W{1'b0}}, count_d};

	// Control: accept, update, result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= busy_q;
			if (load) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q  <= 1'b0;
				count_q <= count_d;
			end
		end
	end

	// Command and result registers.
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= req;
		end
		if (busy_q) begin
			rsp_q.owner_id    <= owner_d;
			rsp_q.status      <= status_d;
			rsp_q.entry_count <= count_ext[OCNT_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// A command in flight is finished and reported in the next cycle.
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> (!busy_q && done_q))
		else $error("command held busy for more than one cycle");

	// Every result strobe follows a busy cycle.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result strobe without a command");

	// The sorted chain has at most one boundary cell.
	a_bnd_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(bnd_vec))
		else $error("ring order broken: several boundary cells");

	// The entry count never passes the ring depth.
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RING_ENTRIES))
		else $error("entry count above ring depth");

endmodule

// ===== bench/chrt_ring_checker.sv =====
// ----------------------------------------------------------------------------
// Consistent-hash ring table result checker
// Watches the command and result channels of the ring table core, keeps its
// own sorted ring to predict every result beat, and counts mismatches.
// ----------------------------------------------------------------------------
module chrt_ring_checker import chrt_pkg::*; #(
	parameter int unsigned DEPTH = RING_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Predicted ring contents, kept sorted by key in ascending order.
	logic [KEY_W-1:0] ring_key_tbl [DEPTH];
	logic [OWN_W-1:0] ring_owner_tbl [DEPTH];
	int               ring_size = 0;

	// Result beats predicted but not yet seen on the result port.
	rsp_t expected_rsp_q [$];
	rsp_t want;

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $realtime, msg);
		fail_count++;
	endtask

	// Apply one command to the predicted ring and return its result beat.
	function automatic rsp_t ring_apply(input req_t cmd);
		rsp_t res;
		int   pos;
		int   i;
		bit   hit;
		res = '0;
		res.status = ST_OK;
		pos = 0;
		while (pos < ring_size && ring_key_tbl[pos] < cmd.key_hash) begin
			pos++;
		end
		hit = (pos < ring_size) && (ring_key_tbl[pos] == cmd.key_hash);
		case (cmd.mode)
			MODE_INSERT: begin
				if (hit) begin
					res.status = ST_DUP;
				end else if (ring_size >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (i = ring_size; i > pos; i--) begin
						ring_key_tbl[i]   = ring_key_tbl[i-1];
						ring_owner_tbl[i] = ring_owner_tbl[i-1];
					end
					ring_key_tbl[pos]   = cmd.key_hash;
					ring_owner_tbl[pos] = cmd.node_id;
					ring_size++;
				end
			end
			MODE_REMOVE: begin
				if (!hit) begin
					res.status = ST_ABSENT;
				end else begin
					for (i = pos; i + 1 < ring_size; i++) begin
						ring_key_tbl[i]   = ring_key_tbl[i+1];
						ring_owner_tbl[i] = ring_owner_tbl[i+1];
					end
					ring_size--;
				end
			end
			MODE_LOOKUP: begin
				if (ring_size == 0) begin
					res.status = ST_EMPTY;
				end else begin
					// Past the largest key the ring wraps to the smallest one.
					if (pos >= ring_size) begin
						pos = 0;
					end
					res.owner_id = ring_owner_tbl[pos];
				end
			end
			default: begin
			end
		endcase
		res.entry_count = OCNT_W'(ring_size);
		return res;
	endfunction

	// Result beats are checked before a command beat taken at the same edge is
	// predicted, since that command's result always comes later.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat owner=%0d status=%0d count=%0d",
						rsp.owner_id, rsp.status, rsp.entry_count));
				end else begin
					want = expected_rsp_q.pop_front();
					pending_count--;
					if (rsp.owner_id !== want.owner_id) begin
						report_mismatch($sformatf("owner_id expected %0d, got %0d",
							want.owner_id, rsp.owner_id));
					end
					if (rsp.status !== want.status) begin
						report_mismatch($sformatf("status expected %0d, got %0d",
							want.status, rsp.status));
					end
					if (rsp.entry_count !== want.entry_count) begin
						report_mismatch($sformatf("entry_count expected %0d, got %0d",
							want.entry_count, rsp.entry_count));
					end
				end
			end
			if (start && !busy) begin
				expected_rsp_q.push_back(ring_apply(req));
				pending_count++;
			end
		end
	end

endmodule

// ===== bench/consistent_hash_ring_table_core_test.sv =====
// ----------------------------------------------------------------------------
// Consistent-hash ring table core testbench
// Drives directed and random insert, remove and lookup command beats, fills
// the ring to capacity and drains it to empty, while a checker beside the core
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module consistent_hash_ring_table_core_test import chrt_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_SIZE = 512;
	localparam logic [KEY_W-1:0] KEY_ALL_ONES = '1;
	localparam logic [KEY_W-1:0] KEY_MID = 34'h2_AAAA_AAAA;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	int   fail_count;
	int   pending_count;

	// Keys shared by inserts and removes so that hits are frequent.
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               sweep_order [POOL_SIZE];
	bit               gaps_on;

	consistent_hash_ring_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	chrt_ring_checker #(.DEPTH(RING_ENTRIES_DEF)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the core stops answering.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [KEY_W-1:0] rand_key();
		return {2'($urandom_range(0, 3)), 32'($urandom)};
	endfunction

	// Send one command beat, with a random gap before it when gaps are on.
	task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
			input logic [OWN_W-1:0] node);
		req_t cmd;
		cmd.mode = mode;
		cmd.key_hash = key;
		cmd.node_id = node;
		if (gaps_on && $urandom_range(0, 99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		req <= cmd;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Lookup key: a pool key, a neighbor of one, or anything at all.
	task automatic send_lookup(input int span);
		logic [KEY_W-1:0] key;
		case ($urandom_range(0, 2))
			0: key = key_pool[$urandom_range(0, span - 1)];
			1: key = key_pool[$urandom_range(0, span - 1)] + KEY_W'($urandom_range(0, 2)) - 1'b1;
			default: key = rand_key();
		endcase
		send_cmd(MODE_LOOKUP, key, 4'($urandom));
	endtask

	// Random mix of operations on keys from the first span entries of the pool.
	task automatic send_mix(input int count, input int ins_pct, input int rem_pct,
			input int look_pct, input int span);
		int roll;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < ins_pct) begin
				send_cmd(MODE_INSERT, key_pool[$urandom_range(0, span - 1)], 4'($urandom));
			end else if (roll < ins_pct + rem_pct) begin
				send_cmd(MODE_REMOVE, key_pool[$urandom_range(0, span - 1)], 4'($urandom));
			end else if (roll < ins_pct + rem_pct + look_pct) begin
				send_lookup(span);
			end else begin
				send_cmd(MODE_NOP, rand_key(), 4'($urandom));
			end
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	initial begin
		int i;
		int j;
		int tmp;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		gaps_on = 1'b1;

		key_pool[0] = '0;
		key_pool[1] = KEY_ALL_ONES;
		key_pool[2] = 34'd1;
		key_pool[3] = KEY_ALL_ONES - 1'b1;
		key_pool[4] = KEY_MID;
		for (i = 5; i < POOL_SIZE; i++) begin
			key_pool[i] = rand_key();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty ring, ends of the key range, duplicates, hits, the
		// wrap past the largest key, absent removes and the unused mode.
		send_cmd(MODE_LOOKUP, '0, 4'h0);
		send_cmd(MODE_REMOVE, 34'd5, 4'h0);
		send_cmd(MODE_NOP, '0, 4'h0);
		send_cmd(MODE_INSERT, '0, 4'hF);
		send_cmd(MODE_INSERT, KEY_ALL_ONES, 4'hA);
		send_cmd(MODE_INSERT, '0, 4'h3);
		send_cmd(MODE_INSERT, KEY_MID, 4'h5);
		send_cmd(MODE_LOOKUP, '0, 4'h0);
		send_cmd(MODE_LOOKUP, 34'd1, 4'h0);
		send_cmd(MODE_LOOKUP, KEY_MID + 1'b1, 4'h0);
		send_cmd(MODE_LOOKUP, KEY_ALL_ONES, 4'h0);
		send_cmd(MODE_REMOVE, KEY_ALL_ONES, 4'h0);
		send_cmd(MODE_LOOKUP, 34'h3_0000_0000, 4'h0);
		send_cmd(MODE_REMOVE, KEY_ALL_ONES, 4'h0);
		send_cmd(MODE_LOOKUP, 34'h1_5555_5555, 4'hF);
		send_cmd(MODE_NOP, KEY_ALL_ONES, 4'hF);
		send_cmd(MODE_REMOVE, '0, 4'h0);
		send_cmd(MODE_REMOVE, KEY_MID, 4'h0);
		send_cmd(MODE_LOOKUP, KEY_MID, 4'h0);

		// Balanced traffic on a small key set: the ring stays shallow.
		send_mix(200, 40, 25, 30, 32);

		// Insert-heavy traffic over the whole pool to fill the ring,
		// back to back with no gaps.
		gaps_on = 1'b0;
		send_mix(500, 85, 5, 10, POOL_SIZE);
		gaps_on = 1'b1;

		// Hold off until every result beat is back.
		wait_drained();

		// Remove every pool key in shuffled order, so the ring ends empty.
		for (i = 0; i < POOL_SIZE; i++) begin
			sweep_order[i] = i;
		end
		for (i = POOL_SIZE - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = sweep_order[i];
			sweep_order[i] = sweep_order[j];
			sweep_order[j] = tmp;
		end
		for (i = 0; i < POOL_SIZE; i++) begin
			if ($urandom_range(0, 99) < 25) begin
				send_lookup(POOL_SIZE);
			end
			send_cmd(MODE_REMOVE, key_pool[sweep_order[i]], 4'($urandom));
		end

		// Mixed traffic again after the ring has emptied.
		send_mix(200, 40, 25, 30, 64);

		wait_drained();
		repeat (5) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== consistent_hash_ring_table_core.f =====
src/chrt_pkg.sv
src/chrt_cell.sv
src/consistent_hash_ring_table_core.sv
bench/chrt_ring_checker.sv
bench/consistent_hash_ring_table_core_test.sv
